/* src/urrb_pkg.sv */
// package for the uart receive ring buffer with timed reads
// operation and status codes, field widths and default sizes; no dependencies
package urrb_pkg;

   // default ring size in slots, one slot always stays free
   localparam int DEPTH_DEFAULT = 64;

   // payload field widths
   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int TICK_W   = 16;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 6;

   // reset value of the error mask: framing, parity and overrun bits
   localparam logic [BYTE_W-1:0] ERROR_MASK_RESET = 8'h1C;

   // operation codes
   localparam logic [OP_W-1:0] OP_RX   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   // read answer codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd3;

endpackage

/* src/urrb_ring.sv */
// byte storage of the receive ring: one write port, one read port
// read data registered; uses urrb_pkg
module urrb_ring
   import urrb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/uart_rx_ring_buffer_timed_read_core.sv */
// Timing: answers without a popped byte (empty, busy, timeout) are registered
// in the response register; an answer that pops a byte passes the ring read register first.
// Throughput: one item per cycle while the response slot is free; after a transfer that
// pops a byte, no new item is taken until the byte is back from the ring memory.
// Reset (synchronous): indexes, count, sticky flags, pending read cleared,
// error mask back to 0x1C; ring contents are not cleared.
module uart_rx_ring_buffer_timed_read_core
   import urrb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [BYTE_W-1:0]   csr_wr_data,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic [BYTE_W-1:0]   req_line_status,
   input  logic [TICK_W-1:0]   req_timeout_ticks,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_read_status,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic [FILL_W-1:0]   rsp_fill_count,
   output logic [BYTE_W-1:0]   rsp_line_errors,
   output logic                rsp_overflow_seen
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   // controller states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   logic                state_ff, state_in;
   logic [BYTE_W-1:0]   mask_ff;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic [AW-1:0]       wr_idx_ff, wr_idx_in;
   logic [AW-1:0]       count_ff, count_in;
   logic [BYTE_W-1:0]   err_ff, err_in;
   logic                ovf_ff, ovf_in;
   logic                pend_ff, pend_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;
   logic [BYTE_W-1:0]   rsp_err_ff, rsp_err_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                accept;
   logic                mem_wr_en, mem_rd_en;
   logic [BYTE_W-1:0]   mem_rd_data;
   logic [TICK_W-1:0]   ticks_dec;

   // byte storage
   urrb_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_rx_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rd_data)
   );

   // take a transfer only when idle and the response slot is free
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign ticks_dec = ticks_ff - TICK_W'(1);

   // item decode and state update
   always_comb begin
      state_in      = S_IDLE;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      ovf_in        = ovf_ff;
      pend_in       = pend_ff;
      ticks_in      = ticks_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (state_ff == S_POP) begin
         // popped byte is back from memory
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_data_in   = mem_rd_data;
         rsp_fill_in   = FILL_W'(count_ff);
         rsp_err_in    = err_ff;
         rsp_ovf_in    = ovf_ff;
      end else if (accept) begin
         // answers without data use the current sticky state and fill
         rsp_data_in = '0;
         rsp_fill_in = FILL_W'(count_ff);
         rsp_err_in  = err_ff;
         rsp_ovf_in  = ovf_ff;
         unique case (req_op)
            OP_RX: begin
               if ((req_line_status & mask_ff) != '0) begin
                  err_in = err_ff | req_line_status;
               end else if (count_ff == LAST_IDX) begin
                  ovf_in = 1'b1;
               end else begin
                  mem_wr_en = 1'b1;
                  wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + AW'(1);
                  count_in  = count_ff + AW'(1);
               end
            end
            OP_READ: begin
               if (pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BUSY;
               end else if (count_ff != '0) begin
                  mem_rd_en = 1'b1;
                  rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + AW'(1);
                  count_in  = count_ff - AW'(1);
                  state_in  = S_POP;
               end else if (req_timeout_ticks == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  pend_in  = 1'b1;
                  ticks_in = req_timeout_ticks;
               end
            end
            OP_TICK: begin
               if (pend_ff) begin
                  ticks_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     pend_in       = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_TIMEOUT;
                  end else if (count_ff != '0) begin
                     pend_in   = 1'b0;
                     ticks_in  = '0;
                     mem_rd_en = 1'b1;
                     rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + AW'(1);
                     count_in  = count_ff - AW'(1);
                     state_in  = S_POP;
                  end
               end
            end
            default: begin
               // unused op code, no effect
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= ERROR_MASK_RESET;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         count_ff     <= '0;
         err_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_status   = rsp_status_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_fill_count    = rsp_fill_ff;
   assign rsp_line_errors   = rsp_err_ff;
   assign rsp_overflow_seen = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   // a pop cycle always follows an accepted transfer
   a_pop_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> $past(req_valid && req_ready))
      else $error("pop state without a preceding transfer");

   // the response slot is free when popped data arrives
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> !rsp_valid_ff)
      else $error("popped byte would overwrite a pending response");

   // a pending read always has ticks left
   a_pend_ticks: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (ticks_ff != '0))
      else $error("pending read with zero ticks left");

   // the ring never holds more than depth minus one bytes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_IDX)
      else $error("ring fill count out of range");
`endif

endmodule
